// ===== hw/rtl/bnc_pkg.sv =====
// Package for the bracket nesting checker: stack sizing, symbol codes and
// the helper functions that classify a byte. No dependencies.
package bnc_pkg;

   // Stack sizing.
   localparam int STACK_DEPTH = 1024;
   localparam int ADDR_W      = $clog2(STACK_DEPTH);
   localparam int LEVEL_W     = $clog2(STACK_DEPTH + 1);

   // Two-bit codes held on the stack.
   localparam logic [1:0] CODE_ROUND  = 2'd0;
   localparam logic [1:0] CODE_SQUARE = 2'd1;
   localparam logic [1:0] CODE_CURLY  = 2'd2;
   localparam logic [1:0] CODE_OTHER  = 2'd3;

   // ASCII bracket characters.
   localparam logic [7:0] CHAR_ROUND_OPEN   = 8'h28;
   localparam logic [7:0] CHAR_ROUND_CLOSE  = 8'h29;
   localparam logic [7:0] CHAR_SQUARE_OPEN  = 8'h5B;
   localparam logic [7:0] CHAR_SQUARE_CLOSE = 8'h5D;
   localparam logic [7:0] CHAR_CURLY_OPEN   = 8'h7B;
   localparam logic [7:0] CHAR_CURLY_CLOSE  = 8'h7D;

   // One result transaction as it travels from the core to the output buffer.
   typedef struct packed {
      logic valid;
      logic nested;
      logic overflowed;
   } bnc_result_type;

   // Code that a non-closing byte is pushed as.
   function automatic logic [1:0] opener_code(input logic [7:0] byte_val);
      logic [1:0] code;
      case (byte_val)
         CHAR_ROUND_OPEN:  code = CODE_ROUND;
         CHAR_SQUARE_OPEN: code = CODE_SQUARE;
         CHAR_CURLY_OPEN:  code = CODE_CURLY;
         default:          code = CODE_OTHER;
      endcase
      return code;
   endfunction

   // True when the byte is one of the three closing brackets.
   function automatic logic is_closer(input logic [7:0] byte_val);
      return (byte_val == CHAR_ROUND_CLOSE) || (byte_val == CHAR_SQUARE_CLOSE) ||
             (byte_val == CHAR_CURLY_CLOSE);
   endfunction

   // Opener code that a closing bracket must find on top of the stack.
   function automatic logic [1:0] closer_code(input logic [7:0] byte_val);
      logic [1:0] code;
      case (byte_val)
         CHAR_ROUND_CLOSE:  code = CODE_ROUND;
         CHAR_SQUARE_CLOSE: code = CODE_SQUARE;
         CHAR_CURLY_CLOSE:  code = CODE_CURLY;
         default:           code = CODE_OTHER;
      endcase
      return code;
   endfunction

endpackage

// ===== hw/rtl/bnc_core.sv =====
// Stack engine of the bracket nesting checker: opener memory, cached top
// entry, level counter and sticky flags. Depends on bnc_pkg.
module bnc_core (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    take,
   input  logic [7:0]              symbol,
   input  logic                    symbol_present,
   input  logic                    last_symbol,
   output bnc_pkg::bnc_result_type result
);
   import bnc_pkg::*;

   logic [1:0]         stack_mem [STACK_DEPTH];
   logic [1:0]         rd_data_ff;
   logic [1:0]         top_ff, top_in;
   logic [LEVEL_W-1:0] level_ff, level_in, step_level;
   logic               fail_ff, fail_in, step_fail;
   logic               ovf_ff, ovf_in, step_ovf;
   logic               wr_en;
   logic [1:0]         wr_code;
   logic [ADDR_W-1:0]  rd_addr;
   logic [LEVEL_W-1:0] rd_level;
   logic               closer;

   assign closer = is_closer(symbol);

   // Effect of one symbol on the stack; the entry below the cached top was
   // fetched in the previous cycle and is on rd_data_ff.
   always_comb begin
      step_level = level_ff;
      step_fail  = fail_ff;
      step_ovf   = ovf_ff;
      top_in     = top_ff;
      wr_en      = 1'b0;
      wr_code    = opener_code(symbol);
      if (take && symbol_present) begin
         if (closer) begin
            if (level_ff == '0 || top_ff != closer_code(symbol)) begin
               step_fail = 1'b1;
            end else begin
               step_level = level_ff - LEVEL_W'(1);
               top_in     = rd_data_ff;
            end
         end else if (level_ff >= LEVEL_W'(STACK_DEPTH)) begin
            step_fail = 1'b1;
            step_ovf  = 1'b1;
         end else begin
            wr_en      = 1'b1;
            top_in     = wr_code;
            step_level = level_ff + LEVEL_W'(1);
         end
      end
   end

   // Result on the last item, then the string state clears.
   always_comb begin
      result.valid      = take && last_symbol;
      result.nested     = !step_fail && (step_level == '0);
      result.overflowed = step_ovf;
      level_in          = step_level;
      fail_in           = step_fail;
      ovf_in            = step_ovf;
      if (take && last_symbol) begin
         level_in = '0;
         fail_in  = 1'b0;
         ovf_in   = 1'b0;
      end
   end

   // Prefetch the entry below the next top. It never meets this cycle's write,
   // which goes to the slot above the current top.
   assign rd_level = level_in - LEVEL_W'(2);
   assign rd_addr  = rd_level[ADDR_W-1:0];

   // Opener memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         stack_mem[level_ff[ADDR_W-1:0]] <= wr_code;
      end
      rd_data_ff <= stack_mem[rd_addr];
   end

   // Cached top entry needs no reset; it is read only while the stack holds data.
   always_ff @(posedge clock) begin
      top_ff <= top_in;
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= '0;
         fail_ff  <= 1'b0;
         ovf_ff   <= 1'b0;
      end else begin
         level_ff <= level_in;
         fail_ff  <= fail_in;
         ovf_ff   <= ovf_in;
      end
   end

`ifndef SYNTHESIS
   // The level never passes the stack size.
   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      level_ff <= LEVEL_W'(STACK_DEPTH))
      else $error("stack level above depth");

   // An overflow is always also a failure.
   a_ovf_fails: assert property (@(posedge clock) disable iff (reset)
      ovf_ff |-> fail_ff)
      else $error("overflow without failure");

   // The last item of a string leaves the state cleared.
   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      take && last_symbol |=> level_ff == '0 && !fail_ff && !ovf_ff)
      else $error("state not cleared after last item");

   // A push never writes beyond the stack.
   a_write_bound: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> level_ff < LEVEL_W'(STACK_DEPTH))
      else $error("push beyond stack depth");
`endif

endmodule

// ===== hw/rtl/bracket_nesting_checker.sv =====
// Top level of the bracket nesting checker: stream handshake and a two-entry
// result buffer around bnc_core. Depends on bnc_pkg and bnc_core.
//
// Usage: feed a string one byte per transaction on the req_ channel. req_tdata
// carries the byte, req_tuser says whether a byte is present, and req_tlast
// marks the final item of the string. An item with no byte and tlast set ends
// the string, which may then be empty; one with no byte and no tlast is ignored.
// Each string gives exactly one transaction on the rsp_ channel, on its last
// item: bit 0 is nested, bit 1 is overflowed (more than 1024 open entries).
// Throughput: one item per cycle while req_tready is high. The stack memory
// does one read and one write per cycle; the top entry is held in a register
// and the entry below it is prefetched, so consecutive pops need no stall.
// Output: the verdict is registered, in the skid entry while the output is held.
// Stall: results queue in a two-entry buffer; req_tready drops only while
// both entries are full, and rises again when rsp_tready takes one.
// Reset: level, failure flags and the buffer clear synchronously; the stack
// memory is not cleared and needs no clearing pass.
module bracket_nesting_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] symbol
   input  logic       req_tuser,   // [0] symbol_present
   input  logic       req_tlast,   // last_symbol
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata    // [0] nested, [1] overflowed, [7:2] zero
);
   import bnc_pkg::*;

   bnc_result_type result;
   logic           take;
   logic           out_valid_ff, skid_valid_ff;
   logic [1:0]     out_data_ff, skid_data_ff;
   logic [1:0]     res_data;
   logic           out_free;

   assign req_tready = !skid_valid_ff;
   assign take       = req_tvalid && req_tready;

   bnc_core u_core (
      .clock          (clock),
      .reset          (reset),
      .take           (take),
      .symbol         (req_tdata),
      .symbol_present (req_tuser),
      .last_symbol    (req_tlast),
      .result         (result)
   );

   assign res_data = {result.overflowed, result.nested};
   assign out_free = !out_valid_ff || rsp_tready;

   // Output register with a skid entry behind it.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_free) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= result.valid;
         end else begin
            out_valid_ff  <= result.valid;
         end
      end else if (result.valid) begin
         skid_valid_ff <= 1'b1;
      end
   end

   // Buffer payload, no reset.
   always_ff @(posedge clock) begin
      if (out_free) begin
         out_data_ff  <= skid_valid_ff ? skid_data_ff : res_data;
         skid_data_ff <= res_data;
      end else if (result.valid) begin
         skid_data_ff <= res_data;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {6'b0, out_data_ff};

`ifndef SYNTHESIS
   // The skid entry is filled only behind a held output.
   a_skid_order: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry valid with empty output");

   // An overflowed string is never reported as nested.
   a_ovf_not_nested: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1] |-> !rsp_tdata[0])
      else $error("overflowed string reported nested");

   // A last item taken with out_free and no skid entry shows up in the next cycle.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      take && req_tlast && out_free && !skid_valid_ff |=> rsp_tvalid)
      else $error("result missing one cycle after last item");
`endif

endmodule

// ===== sim/bnc_checker.sv =====
// Checker for the bracket nesting checker: watches the req_ and rsp_ channels,
// predicts each verdict from the accepted symbols and compares. Depends on bnc_pkg.
`timescale 1ns / 1ps

module bnc_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   input  logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] symbol
   input  logic       req_tuser,   // [0] symbol_present
   input  logic       req_tlast,   // last_symbol
   input  logic       rsp_tvalid,
   input  logic       rsp_tready,
   input  logic [7:0] rsp_tdata,   // [0] nested, [1] overflowed, [7:2] zero
   output int         mismatch_count,
   output int         pending_count,
   output int         verdict_count
);
   import bnc_pkg::*;

   typedef struct packed {
      logic nested;
      logic overflowed;
   } verdict_type;

   // Shadow copy of the opener stack and the per-string flags.
   logic [1:0]  open_codes [STACK_DEPTH];
   int          fill;
   logic        string_failed;
   logic        string_overflowed;
   verdict_type verdict_q[$];

   // Apply one symbol to the shadow stack: closers pop on a match, all else pushes while there is room.
   task automatic take_symbol(input logic [7:0] ch);
      logic [1:0] need;
      logic       closing;
      logic [1:0] code;
      closing = 1'b1;
      case (ch)
         CHAR_ROUND_CLOSE:  need = CODE_ROUND;
         CHAR_SQUARE_CLOSE: need = CODE_SQUARE;
         CHAR_CURLY_CLOSE:  need = CODE_CURLY;
         default: begin
            closing = 1'b0;
            need    = CODE_OTHER;
         end
      endcase
      if (closing) begin
         if (fill == 0 || open_codes[fill-1] != need) begin
            string_failed = 1'b1;
         end else begin
            fill--;
         end
      end else if (fill >= STACK_DEPTH) begin
         string_failed     = 1'b1;
         string_overflowed = 1'b1;
      end else begin
         if (ch == CHAR_ROUND_OPEN) code = CODE_ROUND;
         else if (ch == CHAR_SQUARE_OPEN) code = CODE_SQUARE;
         else if (ch == CHAR_CURLY_OPEN) code = CODE_CURLY;
         else code = CODE_OTHER;
         open_codes[fill] = code;
         fill++;
      end
   endtask

   // Compare results first, then fold in the symbol accepted at the same edge;
   // a result at this edge always belongs to an earlier string end.
   always @(posedge clock) begin
      verdict_type want;
      if (reset) begin
         fill              = 0;
         string_failed     = 1'b0;
         string_overflowed = 1'b0;
         mismatch_count    = 0;
         verdict_count     = 0;
         verdict_q.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            verdict_count++;
            if (verdict_q.size() == 0) begin
               $error("result transaction 0x%02h with no verdict pending", rsp_tdata);
               mismatch_count++;
            end else begin
               want = verdict_q.pop_front();
               if (rsp_tdata[0] !== want.nested) begin
                  $error("nested: expected %0d, got %0d", want.nested, rsp_tdata[0]);
                  mismatch_count++;
               end
               if (rsp_tdata[1] !== want.overflowed) begin
                  $error("overflowed: expected %0d, got %0d", want.overflowed, rsp_tdata[1]);
                  mismatch_count++;
               end
               if (rsp_tdata[7:2] !== 6'd0) begin
                  $error("padding: expected 0, got 0x%02h", rsp_tdata[7:2]);
                  mismatch_count++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            if (req_tuser) take_symbol(req_tdata);
            if (req_tlast) begin
               want.nested     = !string_failed && (fill == 0);
               want.overflowed = string_overflowed;
               verdict_q.push_back(want);
               fill              = 0;
               string_failed     = 1'b0;
               string_overflowed = 1'b0;
            end
         end
      end
      pending_count = verdict_q.size();
   end

endmodule

// ===== sim/bracket_nesting_checker_tb.sv =====
// Testbench top for the bracket nesting checker: clock, reset, string stimulus
// and the verdict. Depends on bnc_pkg, bracket_nesting_checker and bnc_checker.
`timescale 1ns / 1ps

module bracket_nesting_checker_tb;
   import bnc_pkg::*;

   logic       clock      = 1'b0;
   logic       reset      = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata  = 8'd0;   // [7:0] symbol
   logic       req_tuser  = 1'b0;   // [0] symbol_present
   logic       req_tlast  = 1'b0;   // last_symbol
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;           // [0] nested, [1] overflowed, [7:2] zero

   int         mismatch_count;
   int         pending_count;
   int         verdict_count;

   // Stimulus bookkeeping.
   logic [7:0] text_q[$];
   logic       quiet       = 1'b0;
   int         symbol_sent = 0;
   int         string_sent = 0;

   always #10 clock = ~clock;

   bracket_nesting_checker u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   bnc_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .req_tlast      (req_tlast),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count),
      .verdict_count  (verdict_count)
   );

   // Receiver backpressure: rsp_tready is low with a chance of about 15 in a hundred, never while quiet.
   always @(posedge clock) begin
      rsp_tready <= quiet || ($urandom_range(99) >= 15);
   end

   // Drive one transaction and hold it until the block accepts it.
   task automatic send_item(input logic [7:0] sym, input logic present, input logic last);
      if (!quiet && $urandom_range(99) < 15) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(3, 1)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= sym;
      req_tuser  <= present;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      if (present) symbol_sent++;
   endtask

   // Send text_q as one string, ended either on its last symbol or by a marker.
   task automatic send_text(input logic end_marker);
      for (int i = 0; i < text_q.size(); i++) begin
         if ($urandom_range(99) < 5) send_item(8'($urandom), 1'b0, 1'b0);
         send_item(text_q[i], 1'b1, !end_marker && (i == text_q.size() - 1));
      end
      if (end_marker || text_q.size() == 0) send_item(8'($urandom), 1'b0, 1'b1);
      string_sent++;
   endtask

   // Stop sending and wait until every verdict has come back.
   task automatic drain();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (pending_count != 0);
      @(posedge clock);
   endtask

   function automatic logic [7:0] random_opener();
      case ($urandom_range(2))
         0:       return CHAR_ROUND_OPEN;
         1:       return CHAR_SQUARE_OPEN;
         default: return CHAR_CURLY_OPEN;
      endcase
   endfunction

   function automatic logic [7:0] closer_of(input logic [7:0] opener);
      if (opener == CHAR_ROUND_OPEN) return CHAR_ROUND_CLOSE;
      if (opener == CHAR_SQUARE_OPEN) return CHAR_SQUARE_CLOSE;
      return CHAR_CURLY_CLOSE;
   endfunction

   // Build a balanced string of the given pairs, then damage it now and then.
   task automatic build_text(input int pairs);
      logic [7:0] open_q[$];
      logic [7:0] ch;
      int         opens_left;
      int         pos;
      text_q.delete();
      opens_left = pairs;
      for (int i = 0; i < 2 * pairs; i++) begin
         if (opens_left > 0 && (open_q.size() == 0 || $urandom_range(1))) begin
            ch = random_opener();
            open_q.push_back(ch);
            text_q.push_back(ch);
            opens_left--;
         end else begin
            text_q.push_back(closer_of(open_q.pop_back()));
         end
      end
      case ($urandom_range(9))
         0, 1: begin
            // Replace one symbol with a closing bracket or any byte.
            if (text_q.size() > 0) begin
               pos = $urandom_range(text_q.size() - 1);
               text_q[pos] = $urandom_range(1) ? closer_of(random_opener()) : 8'($urandom);
            end
         end
         2: begin
            // Drop one symbol.
            if (text_q.size() > 0) text_q.delete($urandom_range(text_q.size() - 1));
         end
         3: begin
            // Stray closer at the front.
            text_q.push_front(closer_of(random_opener()));
         end
         4: begin
            // Plain noise.
            text_q.delete();
            repeat ($urandom_range(12)) text_q.push_back(8'($urandom));
         end
         default: ;
      endcase
   endtask

   initial begin
      logic [7:0] deep_q[$];
      int         random_base;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed strings: empty, each bracket kind, nesting, failures and noise bytes.
      text_q = {};                                              send_text(1'b1);
      text_q = {CHAR_ROUND_OPEN, CHAR_ROUND_CLOSE};             send_text(1'b0);
      text_q = {CHAR_SQUARE_OPEN, CHAR_SQUARE_CLOSE};           send_text(1'b1);
      text_q = {CHAR_CURLY_OPEN, CHAR_CURLY_CLOSE};             send_text(1'b0);
      text_q = {CHAR_ROUND_OPEN, CHAR_SQUARE_OPEN, CHAR_CURLY_OPEN,
                CHAR_CURLY_CLOSE, CHAR_SQUARE_CLOSE, CHAR_ROUND_CLOSE};
      send_text(1'b0);
      text_q = {CHAR_ROUND_OPEN, CHAR_SQUARE_CLOSE};            send_text(1'b0);
      text_q = {CHAR_CURLY_CLOSE};                              send_text(1'b0);
      text_q = {8'h00};                                         send_text(1'b0);
      text_q = {8'hFF, CHAR_ROUND_CLOSE};                       send_text(1'b1);
      // A failure stays sticky even when the rest balances.
      text_q = {CHAR_ROUND_CLOSE, CHAR_ROUND_OPEN, CHAR_ROUND_CLOSE};
      send_text(1'b0);
      // An item with no symbol and no end in the middle of a string is ignored.
      send_item(8'hFF, 1'b1, 1'b0);
      send_item(CHAR_ROUND_CLOSE, 1'b0, 1'b0);
      send_item(8'h00, 1'b0, 1'b1);
      string_sent++;

      // Fill the stack exactly to its depth, then unwind it: still nested.
      deep_q.delete();
      repeat (STACK_DEPTH) deep_q.push_back(random_opener());
      text_q = deep_q;
      for (int i = STACK_DEPTH - 1; i >= 0; i--) text_q.push_back(closer_of(deep_q[i]));
      send_text(1'b0);
      // One push past the depth overflows the string.
      text_q = deep_q;
      text_q.push_back(CHAR_CURLY_OPEN);
      send_text(1'b1);

      // Random strings, mostly well formed; a quiet stretch and a stretch of full drains.
      random_base = symbol_sent;
      while (symbol_sent - random_base < 600) begin
         quiet = (symbol_sent - random_base >= 200) && (symbol_sent - random_base < 350);
         if (symbol_sent - random_base >= 400 && symbol_sent - random_base < 420) drain();
         build_text($urandom_range(99) < 85 ? $urandom_range(6) : $urandom_range(20));
         send_text($urandom_range(3) == 0);
      end
      quiet = 1'b0;

      // Let the last verdicts come out, then wait before the summary.
      drain();
      repeat (10) @(posedge clock);

      $display("Sent %0d strings with %0d symbols, including a full-depth and an overflowing one.",
               string_sent, symbol_sent);
      $display("Checked %0d verdicts against the prediction.", verdict_count);
      if (mismatch_count == 0 && pending_count == 0 && verdict_count == string_sent) begin
         $display("bracket_nesting_checker_tb passed");
      end else begin
         $display("bracket_nesting_checker_tb failed");
      end
      $finish;
   end

   // Watchdog in case the handshake hangs.
   initial begin
      #20_000_000;
      $display("bracket_nesting_checker_tb failed");
      $finish;
   end

endmodule
